@@ hdl/esp_pkg.sv @@
// ============================================================================
// esp_pkg: shared constants and types for the encoder speed estimator
// Field widths, register indexes, reset values and rpm scaling constants.
// ============================================================================
package esp_pkg;

  localparam int TIME_W    = 32;
  localparam int POS_W     = 32;
  localparam int SPD_W     = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CPR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IC  = 2'd2;

  // word kinds on the input channel
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_W-1:0] CPR_RST = 16'd330;
  localparam logic [CFG_W-1:0] FB_RST  = 16'd55968;
  localparam logic [CFG_W-1:0] IC_RST  = 16'd4771;

  localparam int TIME_WIDTH_DEF    = 32;
  localparam int RPM_FRAC_BITS_DEF = 8;

  // 60e6 us/min = 234375 * 2^8
  localparam int               FACTOR_W        = 18;
  localparam logic [FACTOR_W-1:0] USEC_MIN_FACTOR = 18'd234375;
  localparam int               RPM_BASE_SHIFT  = 8;

  // low-pass: Q0.16 coefficients, one coefficient bit per step
  localparam int LPF_ACC_W = 44;
  localparam int LPF_STEPS = CFG_W;
  localparam int LPF_ROUND = 32768;

  typedef logic signed [SPD_W-1:0] spd_t;

  localparam spd_t SPD_MAX = 24'sh7FFFFF;
  localparam spd_t SPD_MIN = 24'sh800000;

  typedef struct packed {
    logic [CFG_W-1:0] fb;
    logic [CFG_W-1:0] ic;
  } lpf_coef_t;

endpackage

@@ hdl/esp_in_if.sv @@
// ============================================================================
// esp_in_if: input channel of the encoder speed estimator
// Valid/ready channel carrying one edge or sample tick word.
// ============================================================================
interface esp_in_if;
  import esp_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic              b_level;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, output op, output b_level, output time_us, input ready);
  modport sink   (input valid, input op, input b_level, input time_us, output ready);
endinterface

@@ hdl/esp_out_if.sv @@
// ============================================================================
// esp_out_if: result channel of the encoder speed estimator
// Valid/ready channel carrying position and the four speed figures.
// ============================================================================
interface esp_out_if;
  import esp_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  spd_t             rpm_diff;
  spd_t             rpm_diff_filtered;
  spd_t             rpm_period;
  spd_t             rpm_period_filtered;

  modport source (output valid, output position, output rpm_diff,
                  output rpm_diff_filtered, output rpm_period,
                  output rpm_period_filtered, input ready);
  modport sink   (input valid, input position, input rpm_diff,
                  input rpm_diff_filtered, input rpm_period,
                  input rpm_period_filtered, output ready);
endinterface

@@ hdl/encoder_speed_estimator.sv @@
// Sequencing: an edge word holds the block until the divider is done; a tick word runs
//   the divider and then both filters, and its result is loaded, once the output can take
//   it, as the input is freed; zero change or zero time skip division.
// Words are taken one at a time; the serial divider (one quotient bit per cycle
//   over 59 + RPM_FRAC_BITS bits) sets the pace, ticks add 16 filter steps.
// Reset (rst, synchronous): registers to 330 / 55968 / 4771, all speed state zero.
// ============================================================================
// encoder_speed_estimator: encoder position and rpm estimator
// Counts quadrature edges, derives edge-period and difference speeds in rpm
// and smooths both with a first-order low-pass filter.
// ============================================================================
module encoder_speed_estimator #(
  parameter int TIME_WIDTH    = esp_pkg::TIME_WIDTH_DEF,
  parameter int RPM_FRAC_BITS = esp_pkg::RPM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [esp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esp_pkg::CFG_W-1:0]     cfg_data,
  esp_in_if.sink                        item,
  esp_out_if.source                     result
);
  import esp_pkg::*;

  // stamps wider than 32 bits act as 32
  localparam int TW = (TIME_WIDTH < TIME_W) ? TIME_WIDTH : TIME_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FILT = 2'd2;
  localparam logic [1:0] ST_PUT  = 2'd3;

  logic [1:0]       state;

  // configuration registers
  logic [CFG_W-1:0] cpr;
  logic [CFG_W-1:0] fb;
  logic [CFG_W-1:0] ic;

  // estimator state
  logic [POS_W-1:0] count;
  logic [TW-1:0]    last_edge_time;
  spd_t             edge_speed;
  logic [TW-1:0]    last_sample_time;
  logic [POS_W-1:0] last_sample_count;
  spd_t             diff_filtered;
  spd_t             diff_previous_raw;
  spd_t             period_filtered;
  spd_t             period_previous_raw;

  // work registers
  logic             is_tick;
  logic             div_start;
  logic             div_neg;
  logic [POS_W-1:0] div_mag;
  logic [TW-1:0]    div_dt;
  logic             div_done;
  spd_t             div_speed;
  spd_t             raw_diff;
  logic             lpf_start;
  logic             lpf_diff_done;
  logic             lpf_period_done;
  spd_t             lpf_diff_y;
  spd_t             lpf_period_y;
  lpf_coef_t        coef;

  logic             accept;
  logic [POS_W-1:0] du;
  logic [TW-1:0]    t_now;

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign t_now      = item.time_us[TW-1:0];
  assign du         = count - last_sample_count;
  assign coef       = '{fb: fb, ic: ic};

  // configuration writes; index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cpr <= CPR_RST;
      fb  <= FB_RST;
      ic  <= IC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CPR: cpr <= cfg_data;
        REG_FB:  fb  <= cfg_data;
        REG_IC:  ic  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      div_start           <= 1'b0;
      lpf_start           <= 1'b0;
      is_tick             <= 1'b0;
      count               <= '0;
      last_edge_time      <= '0;
      edge_speed          <= '0;
      last_sample_time    <= '0;
      last_sample_count   <= '0;
      diff_filtered       <= '0;
      diff_previous_raw   <= '0;
      period_filtered     <= '0;
      period_previous_raw <= '0;
      result.valid        <= 1'b0;
    end else begin
      div_start <= 1'b0;
      lpf_start <= 1'b0;
      // a new word loaded in ST_PUT takes the place of the one leaving
      if (result.valid && result.ready && state != ST_PUT) begin
        result.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            div_start <= 1'b1;
            is_tick   <= (item.op == OP_TICK);
            state     <= ST_DIV;
            if (item.op == OP_EDGE) begin
              // edge: step position, period speed of one count
              count          <= item.b_level ? count + POS_W'(1) : count - POS_W'(1);
              div_neg        <= !item.b_level;
              div_mag        <= POS_W'(1);
              div_dt         <= t_now - last_edge_time;
              last_edge_time <= t_now;
            end else begin
              // tick: signed count change since the previous tick
              div_neg           <= du[POS_W-1];
              div_mag           <= du[POS_W-1] ? (~du + POS_W'(1)) : du;
              div_dt            <= t_now - last_sample_time;
              last_sample_time  <= t_now;
              last_sample_count <= count;
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            if (is_tick) begin
              raw_diff  <= div_speed;
              lpf_start <= 1'b1;
              state     <= ST_FILT;
            end else begin
              edge_speed <= div_speed;
              state      <= ST_IDLE;
            end
          end
        end

        ST_FILT: begin
          // both filters run the same number of steps
          if (lpf_diff_done && lpf_period_done) begin
            diff_filtered       <= lpf_diff_y;
            diff_previous_raw   <= raw_diff;
            period_filtered     <= lpf_period_y;
            period_previous_raw <= edge_speed;
            state               <= ST_PUT;
          end
        end

        ST_PUT: begin
          if (!result.valid || result.ready) begin
            result.valid               <= 1'b1;
            result.position            <= count;
            result.rpm_diff            <= diff_previous_raw;
            result.rpm_diff_filtered   <= diff_filtered;
            result.rpm_period          <= period_previous_raw;
            result.rpm_period_filtered <= period_filtered;
            state                      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  esp_div #(
    .TW   (TW),
    .FRAC (RPM_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (div_neg),
    .mag   (div_mag),
    .dt    (div_dt),
    .cpr   (cpr),
    .done  (div_done),
    .speed (div_speed)
  );

  // difference-speed filter: raw value straight from the divider
  esp_lpf u_lpf_diff (
    .clk    (clk),
    .rst    (rst),
    .start  (lpf_start),
    .coef   (coef),
    .y_prev (diff_filtered),
    .x      (raw_diff),
    .x_prev (diff_previous_raw),
    .done   (lpf_diff_done),
    .y      (lpf_diff_y)
  );

  // edge-period filter: latest edge speed
  esp_lpf u_lpf_period (
    .clk    (clk),
    .rst    (rst),
    .start  (lpf_start),
    .coef   (coef),
    .y_prev (period_filtered),
    .x      (edge_speed),
    .x_prev (period_previous_raw),
    .done   (lpf_period_done),
    .y      (lpf_period_y)
  );

endmodule

@@ hdl/esp_div.sv @@
// ============================================================================
// esp_div: bit-serial rpm divider
// Restoring division, one quotient bit per cycle; rounds and saturates.
// ============================================================================
module esp_div #(
  parameter int TW   = 32,
  parameter int FRAC = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       neg,
  input  logic [esp_pkg::POS_W-1:0]  mag,
  input  logic [TW-1:0]              dt,
  input  logic [esp_pkg::CFG_W-1:0]  cpr,
  output logic                       done,
  output esp_pkg::spd_t              speed
);
  import esp_pkg::*;

  localparam int NUM_W = POS_W + FACTOR_W;
  localparam int DEN_W = TW + CFG_W;
  // one extra quotient bit feeds the rounding
  localparam int ITER  = NUM_W + RPM_BASE_SHIFT + FRAC + 1;
  localparam int CNT_W = $clog2(ITER + 1);

  logic             busy;
  logic             finish;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [SPD_W-1:0] quo;
  logic             ovf;
  logic             neg_r;
  logic             zero_mag;
  logic             zero_dt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;
  logic [CFG_W-1:0] cpr_eff;
  logic [SPD_W:0]   quo_inc;
  logic [SPD_W-1:0] q_round;
  logic             sat;

  always_comb begin
    rem_sh   = {rem, num_sh[NUM_W-1]};
    diff     = rem_sh - {1'b0, den};
    fits     = !diff[DEN_W];
    rem_next = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    cpr_eff  = (cpr == '0) ? CFG_W'(1) : cpr;
    quo_inc  = {1'b0, quo} + (SPD_W+1)'(1);
    q_round  = quo_inc[SPD_W:1];
    sat      = ovf || (&quo) || zero_dt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg_r    <= neg;
        zero_mag <= (mag == '0);
        zero_dt  <= (dt == '0);
        num_sh   <= NUM_W'(mag) * NUM_W'(USEC_MIN_FACTOR);
        den      <= DEN_W'(dt) * DEN_W'(cpr_eff);
        rem      <= '0;
        quo      <= '0;
        ovf      <= 1'b0;
        cnt      <= '0;
        // special cases need no division
        if (mag == '0 || dt == '0) begin
          finish <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem    <= rem_next;
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        quo    <= {quo[SPD_W-2:0], fits};
        ovf    <= ovf | quo[SPD_W-1];
        cnt    <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ITER - 1)) begin
          busy   <= 1'b0;
          finish <= 1'b1;
        end
      end else if (finish) begin
        finish <= 1'b0;
        done   <= 1'b1;
        if (zero_mag) begin
          speed <= '0;
        end else if (sat) begin
          speed <= neg_r ? SPD_MIN : SPD_MAX;
        end else begin
          speed <= neg_r ? (~q_round + SPD_W'(1)) : q_round;
        end
      end
    end
  end

endmodule

@@ hdl/esp_lpf.sv @@
// ============================================================================
// esp_lpf: bit-serial first-order low-pass filter
// Shift-add over the coefficient bits, then floor shift and saturation.
// ============================================================================
module esp_lpf (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  esp_pkg::lpf_coef_t coef,
  input  esp_pkg::spd_t      y_prev,
  input  esp_pkg::spd_t      x,
  input  esp_pkg::spd_t      x_prev,
  output logic               done,
  output esp_pkg::spd_t      y
);
  import esp_pkg::*;

  localparam int CNT_W = $clog2(LPF_STEPS);
  localparam int YQ_W  = LPF_ACC_W - CFG_W;

  logic                        busy;
  logic                        finish;
  logic [CNT_W-1:0]            cnt;
  logic [CFG_W-1:0]            fb_sh;
  logic [CFG_W-1:0]            ic_sh;
  logic signed [LPF_ACC_W-1:0] a;
  logic signed [LPF_ACC_W-1:0] b;
  logic signed [LPF_ACC_W-1:0] acc;
  logic signed [SPD_W:0]       xs;
  logic signed [YQ_W-1:0]      yq;

  always_comb begin
    xs = {x[SPD_W-1], x} + {x_prev[SPD_W-1], x_prev};
    yq = acc[LPF_ACC_W-1:CFG_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        fb_sh <= coef.fb;
        ic_sh <= coef.ic;
        a     <= LPF_ACC_W'(y_prev);
        b     <= LPF_ACC_W'(xs);
        acc   <= LPF_ACC_W'(LPF_ROUND);
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= acc + (fb_sh[0] ? a : '0) + (ic_sh[0] ? b : '0);
        a     <= a <<< 1;
        b     <= b <<< 1;
        fb_sh <= fb_sh >> 1;
        ic_sh <= ic_sh >> 1;
        cnt   <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(LPF_STEPS - 1)) begin
          busy   <= 1'b0;
          finish <= 1'b1;
        end
      end else if (finish) begin
        finish <= 1'b0;
        done   <= 1'b1;
        if (yq > YQ_W'(SPD_MAX)) begin
          y <= SPD_MAX;
        end else if (yq < YQ_W'(SPD_MIN)) begin
          y <= SPD_MIN;
        end else begin
          y <= yq[SPD_W-1:0];
        end
      end
    end
  end

endmodule
